// ===== rtl/core/compacting_record_table_macros.svh =====
// Assertion macros for the compacting record table.
// Included by the top level; it needs no other file.
`ifndef COMPACTING_RECORD_TABLE_MACROS_SVH
`define COMPACTING_RECORD_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crt_pkg.sv =====
// Shared constants and controller/datapath interface types of the record table.
// Used by crt_ctrl, crt_dpath and compacting_record_table; depends on nothing.
package crt_pkg;

    localparam int DEF_TABLE_DEPTH = 8;
    localparam int FUNC_W          = 2;
    localparam int KEY_W           = 24;
    localparam int VAL_W           = 32;
    localparam int STATUS_W        = 3;
    localparam int SLOT_W          = 6;

    // Operation codes; code 3 is unused and the item is dropped.
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;

    typedef struct packed {
        logic                latch;     // capture the incoming item
        logic                ptr_clr;
        logic                ptr_inc;
        logic                rd_en;     // read the entry at the pointer
        logic                rd_next;   // read at pointer plus one instead
        logic                wr_add;    // append the item at the fill count
        logic                wr_shift;  // move the read entry to the pointer
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_res;
        logic [STATUS_W-1:0] res_code;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;        // operation of the item in work
        logic              count_zero;
        logic              full;
        logic              hit;         // read key equals the item key
        logic              last;        // pointer plus one reaches the count
        logic              last2;       // pointer plus two reaches the count
    } t_stat;

endpackage

// ===== rtl/core/crt_dpath.sv =====
// Datapath of the record table: key and value memories, fill count, scan
// pointer, result and output registers. Depends on crt_pkg.
module crt_dpath #(
    parameter int TABLE_DEPTH = crt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crt_pkg::t_cmd                 i_cmd,
    output crt_pkg::t_stat                o_stat,
    input  logic [crt_pkg::FUNC_W-1:0]    i_func,
    input  logic [crt_pkg::KEY_W-1:0]     i_key,
    input  logic [crt_pkg::VAL_W-1:0]     i_value,
    output logic [crt_pkg::STATUS_W-1:0]  o_status,
    output logic [crt_pkg::SLOT_W-1:0]    o_slot,
    output logic [crt_pkg::VAL_W-1:0]     o_found_value
);
    import crt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CNT_W + 1;

    logic [KEY_W-1:0]    r_key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]    r_val_mem [TABLE_DEPTH];

    logic [FUNC_W-1:0]   r_func;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    logic [IDX_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [KEY_W-1:0]    r_rd_key;
    logic [VAL_W-1:0]    r_rd_val;
    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [VAL_W-1:0]    r_res_val;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic [VAL_W-1:0]    r_found_value;

    logic [IDX_W-1:0]    ptr_next;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [EXT_W-1:0]    ptr_ext;
    logic [EXT_W-1:0]    cnt_ext;

    assign ptr_next = r_ptr + IDX_W'(1);
    assign rd_addr  = i_cmd.rd_next ? ptr_next : r_ptr;
    assign wr_addr  = i_cmd.wr_add ? IDX_W'(r_count) : r_ptr;
    assign ptr_ext  = EXT_W'(r_ptr);
    assign cnt_ext  = EXT_W'(r_count);

    always_comb begin
        o_stat.func       = r_func;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count == CNT_W'(TABLE_DEPTH));
        o_stat.hit        = (r_rd_key == r_key);
        o_stat.last       = (ptr_ext + EXT_W'(1)) >= cnt_ext;
        o_stat.last2      = (ptr_ext + EXT_W'(2)) >= cnt_ext;
    end

    // One write port and one registered read port for both stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_key_mem[wr_addr] <= r_key;
            r_val_mem[wr_addr] <= r_value;
        end else if (i_cmd.wr_shift) begin
            r_key_mem[wr_addr] <= r_rd_key;
            r_val_mem[wr_addr] <= r_rd_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_val <= r_val_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= ptr_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            case (i_cmd.res_code)
                ST_ADDED:             r_res_slot <= SLOT_W'(r_count);
                ST_FOUND, ST_DELETED: r_res_slot <= SLOT_W'(r_ptr);
                default:              r_res_slot <= '0;
            endcase
            r_res_val <= (i_cmd.res_code == ST_FOUND) ? r_rd_val : '0;
        end
        if (i_cmd.load_out) begin
            r_status      <= r_res_status;
            r_slot        <= r_res_slot;
            r_found_value <= r_res_val;
        end
    end

    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_found_value = r_found_value;

endmodule

// ===== rtl/core/crt_ctrl.sv =====
// Controller of the record table: sequences add, search and delete-with-shift
// and owns the handshakes. Depends on crt_pkg.
module crt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [crt_pkg::FUNC_W-1:0]  i_func,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  crt_pkg::t_stat              i_stat,
    output crt_pkg::t_cmd               o_cmd
);
    import crt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.ptr_clr = 1'b1;
                    case (i_func)
                        FUNC_ADD:                 n_state = S_ADD;
                        FUNC_SEARCH, FUNC_DELETE: n_state = S_RD;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.set_res = 1'b1;
                if (i_stat.full) begin
                    o_cmd.res_code = ST_FULL;
                end else begin
                    o_cmd.wr_add   = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.res_code = ST_ADDED;
                end
                n_state = S_DONE;
            end
            S_RD: begin
                if (i_stat.count_zero) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.func == FUNC_SEARCH) begin
                        o_cmd.res_code = ST_FOUND;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.res_code = ST_DELETED;
                        // A hit in the last entry needs no shift.
                        if (i_stat.last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_SH_RD;
                        end
                    end
                end else if (i_stat.last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                if (i_stat.last2) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/compacting_record_table.sv =====
// Sequence: an add, or a full table, sets its result in the add state; search
// and delete read and compare the entries in turn (an empty table ends at once),
// and a delete then moves each later entry down with a read and a write.
// Throughput: one item at a time; the next is taken once the result is in the
// output register. The entry-by-entry scan through the memories sets the pace.
// Reset: synchronous active low; clears the fill count and the handshakes,
// the stores keep their contents.
`include "compacting_record_table_macros.svh"

module compacting_record_table #(
    parameter int TABLE_DEPTH = crt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [crt_pkg::FUNC_W-1:0]    i_func,
    input  logic [crt_pkg::KEY_W-1:0]     i_key,
    input  logic [crt_pkg::VAL_W-1:0]     i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [crt_pkg::STATUS_W-1:0]  o_status,
    output logic [crt_pkg::SLOT_W-1:0]    o_slot,
    output logic [crt_pkg::VAL_W-1:0]     o_found_value
);
    import crt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    crt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    crt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_found_value (o_found_value)
    );

    `CRT_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, stat.full, !stat.count_zero, "table full and empty at once")
    `CRT_ASSERT_NEXT(a_unused_code_dropped, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_func != FUNC_ADD && i_func != FUNC_SEARCH && i_func != FUNC_DELETE, !o_in_stall, "unused operation code started work")
    `CRT_ASSERT_NEXT(a_add_goes_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_func == FUNC_ADD, o_in_stall, "accepted add did not start work")
    `CRT_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared without an item in work")

endmodule
